@@ hw/rtl/ptal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptal_pkg
// Types, register indexes, mode codes and the log2 table of the tone LUT.
// ----------------------------------------------------------------------------
package ptal_pkg;

  localparam int LOG_W  = 43;   // 3 integer + 40 fraction bits
  localparam int FRAC_W = 40;
  localparam int NUM_W  = 50;   // dividend width
  localparam int DIV_W  = 10;   // divisor width

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_BRIGHT   = 3'd1;
  localparam logic [2:0] CFG_CONTRAST = 3'd2;
  localparam logic [2:0] CFG_GAMMA    = 3'd3;
  localparam logic [2:0] CFG_ALPHA    = 3'd4;

  localparam logic [1:0] MODE_BRIGHT   = 2'd0;
  localparam logic [1:0] MODE_CONTRAST = 2'd1;
  localparam logic [1:0] MODE_GAMMA    = 2'd2;
  localparam logic [1:0] MODE_BYPASS   = 2'd3;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]        adjust_mode;
    logic signed [7:0] brightness_amount;
    logic [9:0]        contrast_amount;
    logic [9:0]        gamma_amount;
    logic              keep_alpha;
  } cfg_regs_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } tab_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SRCH,
    ST_WRITE
  } build_state_t;

  typedef logic [LOG_W-1:0] log_tab_t [256];

  // log2 in Q.40, by repeated squaring of a Q.61 mantissa (elaboration only)
  function automatic log_tab_t build_log_table();
    log_tab_t         tab;
    logic [63:0]      z;
    logic [127:0]     p;
    logic [FRAC_W-1:0] frac;
    int               n;
    tab[0] = '0;
    for (int x = 1; x < 256; x++) begin
      n = 0;
      for (int b = 1; b < 8; b++) begin
        if (((x >> b) & 1) != 0) n = b;
      end
      z = 64'(x) << (61 - n);
      frac = '0;
      for (int i = 0; i < FRAC_W; i++) begin
        p = {64'd0, z} * {64'd0, z};
        z = p[124:61];
        frac = {frac[FRAC_W-2:0], 1'b0};
        if (z[63:62] != 2'b00) begin
          frac[0] = 1'b1;
          z = z >> 1;
        end
      end
      tab[x] = {3'(n), frac};
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TABLE = build_log_table();

endpackage
`default_nettype wire

@@ hw/rtl/pixel_tone_adjust_lut_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_tone_adjust_lut_top
// Three register stages: request register, table read, output register; one
// pixel per cycle sustained when nothing stalls. Table rebuild after reset and
// each write to a mapped register, entry by entry: prep, multiply, divide, write
// (bypass skips to write; gamma adds an 8-step search to a 50-step divider); no
// pixel request is taken meanwhile. Synchronous reset clears the valids.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_lut_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptal_pkg::pix_in_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptal_pkg::pix_out_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [9:0]        cfg_data
);

  ptal_pkg::cfg_regs_t cfg;
  ptal_pkg::tab_wr_t   wr;
  logic                busy;
  logic                cfg_hit;
  logic                adv;

  logic                s1_valid;
  ptal_pkg::pix_in_t   s1_pix;
  logic                s2_valid;
  logic [7:0]          s2_alpha;
  logic [7:0]          rd_r, rd_g, rd_b;

  // register writes are always taken; an index past the list is dropped
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= ptal_pkg::CFG_ALPHA);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adjust_mode       <= ptal_pkg::MODE_BRIGHT;
      cfg.brightness_amount <= 8'sd0;
      cfg.contrast_amount   <= 10'd100;
      cfg.gamma_amount      <= 10'd100;
      cfg.keep_alpha        <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptal_pkg::CFG_MODE:     cfg.adjust_mode       <= cfg_data[1:0];
        ptal_pkg::CFG_BRIGHT:   cfg.brightness_amount <= $signed(cfg_data[7:0]);
        ptal_pkg::CFG_CONTRAST: cfg.contrast_amount   <= cfg_data;
        ptal_pkg::CFG_GAMMA:    cfg.gamma_amount      <= cfg_data;
        ptal_pkg::CFG_ALPHA:    cfg.keep_alpha        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // table builder; restarts from entry 0 on every write to a mapped register
  ptal_build u_build (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_hit),
    .cfg   (cfg),
    .wr    (wr),
    .busy  (busy)
  );

  // whole pipe moves when the output slot is free or being drained
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;

  // stage 1: request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix <= in_data;
    end
  end

  // stage 2: three table copies, one per colour channel
  ptal_ram u_ram_r (
    .clk (clk), .we (wr.en), .waddr (wr.addr), .wdata (wr.data),
    .re (adv), .raddr (s1_pix.red_in), .rdata (rd_r)
  );
  ptal_ram u_ram_g (
    .clk (clk), .we (wr.en), .waddr (wr.addr), .wdata (wr.data),
    .re (adv), .raddr (s1_pix.green_in), .rdata (rd_g)
  );
  ptal_ram u_ram_b (
    .clk (clk), .we (wr.en), .waddr (wr.addr), .wdata (wr.data),
    .re (adv), .raddr (s1_pix.blue_in), .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_alpha <= cfg.keep_alpha ? s1_pix.alpha_in : 8'd255;
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.red_out   <= rd_r;
      out_data.green_out <= rd_g;
      out_data.blue_out  <= rd_b;
      out_data.alpha_out <= s2_alpha;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ptal_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptal_ram
// 256 x 8 table copy, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptal_ram (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [7:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic       re,
  input  wire logic [7:0] raddr,
  output logic      [7:0] rdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ptal_build.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptal_build
// Sequencer that rebuilds the channel table one entry at a time.
// ----------------------------------------------------------------------------
module ptal_build (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire ptal_pkg::cfg_regs_t cfg,
  output ptal_pkg::tab_wr_t        wr,
  output logic                     busy
);

  ptal_pkg::build_state_t state, state_next;

  logic [7:0]                     v;
  logic [ptal_pkg::LOG_W-1:0]     opa;
  logic [ptal_pkg::DIV_W-1:0]     opk;
  logic [ptal_pkg::DIV_W-1:0]     dvs;
  logic                           neg;
  logic [ptal_pkg::NUM_W-1:0]     quo;
  logic [ptal_pkg::DIV_W-1:0]     rem;
  logic [5:0]                     cnt;
  logic [7:0]                     y;
  logic [2:0]                     sbit;
  logic [7:0]                     res;

  logic                           skip_math;
  logic [ptal_pkg::DIV_W:0]       rs;
  logic                           ge;
  logic [ptal_pkg::NUM_W-1:0]     prod;
  logic [34:0]                    recip;
  logic [10:0]                    lq;
  logic signed [13:0]             sv;
  logic signed [14:0]             lin;
  logic [7:0]                     lin_clamped;
  logic [7:0]                     cand;
  logic [ptal_pkg::NUM_W-1:0]     span;
  logic signed [8:0]              vd;

  assign skip_math = (cfg.adjust_mode == ptal_pkg::MODE_BYPASS) ||
                     (cfg.adjust_mode == ptal_pkg::MODE_GAMMA && v == 8'd0);
  assign rs   = {rem, quo[ptal_pkg::NUM_W-1]};
  assign ge   = rs >= {1'b0, dvs};
  assign prod = ptal_pkg::NUM_W'(opa) * ptal_pkg::NUM_W'(opk);
  assign vd   = $signed({1'b0, v}) - 9'sd127;

  // linear modes: divide by 100 as multiply by ceil(2^24/100), exact below 2^17
  assign recip = 35'(quo[16:0]) * 35'd167773;
  assign lq    = recip[34:24];

  // linear modes: signed quotient plus base, clamped to a byte
  always_comb begin
    sv  = neg ? -$signed({3'b000, lq}) : $signed({3'b000, lq});
    lin = (cfg.adjust_mode == ptal_pkg::MODE_BRIGHT) ?
          15'(sv) + $signed({7'd0, v}) : 15'(sv) + 15'sd127;
    if (lin < 0) begin
      lin_clamped = 8'd0;
    end else if (lin > 15'sd255) begin
      lin_clamped = 8'd255;
    end else begin
      lin_clamped = lin[7:0];
    end
  end

  // gamma search probe
  assign cand = y | (8'd1 << sbit);
  assign span = ptal_pkg::NUM_W'(ptal_pkg::LOG_TABLE[255] - ptal_pkg::LOG_TABLE[cand]);

  always_comb begin
    state_next = state;
    case (state)
      ptal_pkg::ST_IDLE:  state_next = ptal_pkg::ST_IDLE;
      ptal_pkg::ST_PREP:  state_next = skip_math ? ptal_pkg::ST_WRITE : ptal_pkg::ST_MUL;
      ptal_pkg::ST_MUL:   state_next = ptal_pkg::ST_DIV;
      ptal_pkg::ST_DIV: begin
        if (cfg.adjust_mode != ptal_pkg::MODE_GAMMA) begin
          state_next = ptal_pkg::ST_WRITE;
        end else if (cnt == 6'(ptal_pkg::NUM_W - 1)) begin
          state_next = ptal_pkg::ST_SRCH;
        end
      end
      ptal_pkg::ST_SRCH:  if (sbit == 3'd0) state_next = ptal_pkg::ST_WRITE;
      ptal_pkg::ST_WRITE: state_next = (v == 8'd255) ? ptal_pkg::ST_IDLE : ptal_pkg::ST_PREP;
      default:            state_next = ptal_pkg::ST_IDLE;
    endcase
    if (start) state_next = ptal_pkg::ST_PREP;
  end

  assign busy    = state != ptal_pkg::ST_IDLE;
  assign wr.en   = state == ptal_pkg::ST_WRITE;
  assign wr.addr = v;
  assign wr.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptal_pkg::ST_PREP;
      v     <= 8'd0;
    end else begin
      state <= state_next;
      if (start) begin
        v <= 8'd0;
      end else if (state == ptal_pkg::ST_WRITE) begin
        v <= v + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ptal_pkg::ST_PREP: begin
        res <= v;
        cnt <= 6'd0;
        rem <= '0;
        case (cfg.adjust_mode)
          ptal_pkg::MODE_BRIGHT: begin
            opa <= ptal_pkg::LOG_W'($unsigned(cfg.brightness_amount[7] ?
                   -cfg.brightness_amount : cfg.brightness_amount));
            opk <= 10'd255;
            neg <= cfg.brightness_amount[7];
            dvs <= 10'd100;
          end
          ptal_pkg::MODE_CONTRAST: begin
            opa <= ptal_pkg::LOG_W'($unsigned(vd[8] ? -vd : vd));
            opk <= cfg.contrast_amount;
            neg <= vd[8];
            dvs <= 10'd100;
          end
          default: begin
            opa <= ptal_pkg::LOG_TABLE[255] - ptal_pkg::LOG_TABLE[v];
            opk <= 10'd100;
            neg <= 1'b0;
            dvs <= (cfg.gamma_amount == 10'd0) ? 10'd1 : cfg.gamma_amount;
          end
        endcase
      end
      ptal_pkg::ST_MUL: begin
        quo <= prod;
      end
      ptal_pkg::ST_DIV: begin
        y    <= 8'd0;
        sbit <= 3'd7;
        if (cfg.adjust_mode == ptal_pkg::MODE_GAMMA) begin
          rem <= ge ? ptal_pkg::DIV_W'(rs - {1'b0, dvs}) : rs[ptal_pkg::DIV_W-1:0];
          quo <= {quo[ptal_pkg::NUM_W-2:0], ge};
          cnt <= cnt + 6'd1;
        end else begin
          res <= lin_clamped;
        end
      end
      ptal_pkg::ST_SRCH: begin
        if (span >= quo) begin
          y <= cand;
          if (sbit == 3'd0) res <= cand;
        end else if (sbit == 3'd0) begin
          res <= y;
        end
        sbit <= sbit - 3'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ tb/pixel_tone_adjust_lut_top_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_tone_adjust_lut_top_tb
// Runs RGBA pixels through the tone table under a sequence of brightness,
// contrast, gamma and bypass settings. Each output pixel is checked against
// a table that this bench builds itself, including the fixed-point gamma
// curve. Both handshakes stall at random, and there is one long output
// hold-off.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_lut_top_tb;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ptal_pkg::pix_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ptal_pkg::pix_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  pixel_tone_adjust_lut_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow registers and the tone curve they give
  logic [1:0]  shadow_mode;
  int          shadow_bright, shadow_contrast, shadow_gamma;
  bit          shadow_keep;
  logic [7:0]  tone_curve [256];
  logic [63:0] log2_fix [256];  // log2(x) in Q.40

  ptal_pkg::pix_in_t  pixel_q [$];      // requests waiting for the driver
  ptal_pkg::pix_out_t expected_pix [$]; // results owed by the block
  int  errors = 0;
  int  pixels_sent = 0, pixels_checked = 0, cfg_writes = 0;
  bit  in_took = 0, cfg_took = 0;
  bit  no_gaps = 0;           // phase with both sides flat out
  bit  long_hold = 0;         // receiver hold-off, driven by its own process
  int  in_gap = 0, out_gap = 0;

  // log2 by repeated squaring of a Q.61 mantissa, 40 fraction bits
  function automatic logic [63:0] fixed_log2(int x);
    int           hb;
    logic [63:0]  m;
    logic [127:0] sq;
    logic [39:0]  fr;
    hb = 0;
    for (int b = 1; b < 8; b++) if (x >> b) hb = b;
    m = 64'(x) << (61 - hb);
    fr = '0;
    for (int i = 0; i < 40; i++) begin
      sq = {64'd0, m} * {64'd0, m};
      m = sq[124:61];
      fr = fr << 1;
      if (m >= (64'd1 << 62)) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(hb) << 40) | 64'(fr);
  endfunction

  function automatic int clamp8(int x);
    return (x < 0) ? 0 : (x > 255) ? 255 : x;
  endfunction

  function automatic int gamma_point(int v, int g);
    logic [63:0] d, t;
    if (v == 0) return 0;
    d = log2_fix[255] - log2_fix[v];
    t = d * 64'd100 / 64'(g);
    for (int y = 255; y >= 1; y--) if (log2_fix[255] - log2_fix[y] >= t) return y;
    return 0;
  endfunction

  function automatic void rebuild_tone_curve();
    int g;
    g = (shadow_gamma == 0) ? 1 : shadow_gamma;
    for (int v = 0; v < 256; v++) begin
      case (shadow_mode)
        ptal_pkg::MODE_BRIGHT:
          tone_curve[v] = 8'(clamp8(v + shadow_bright * 255 / 100));
        ptal_pkg::MODE_CONTRAST:
          tone_curve[v] = 8'(clamp8((v - 127) * shadow_contrast / 100 + 127));
        ptal_pkg::MODE_GAMMA:
          tone_curve[v] = 8'(gamma_point(v, g));
        default:
          tone_curve[v] = 8'(v);
      endcase
    end
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [9:0] val);
    case (idx)
      ptal_pkg::CFG_MODE:     shadow_mode = val[1:0];
      ptal_pkg::CFG_BRIGHT:   shadow_bright = int'($signed(val[7:0]));
      ptal_pkg::CFG_CONTRAST: shadow_contrast = int'(val);
      ptal_pkg::CFG_GAMMA:    shadow_gamma = int'(val);
      ptal_pkg::CFG_ALPHA:    shadow_keep = val[0];
      default:                return;  // unmapped index: no rebuild
    endcase
    rebuild_tone_curve();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             pixels_checked);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // handshake flags, read at the following falling edge
  always @(posedge clk) begin
    in_took  <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // input monitor: predict each accepted request
  always @(posedge clk) begin
    ptal_pkg::pix_out_t e;
    if (!rst && in_valid && in_ready) begin
      e.red_out   = tone_curve[in_data.red_in];
      e.green_out = tone_curve[in_data.green_in];
      e.blue_out  = tone_curve[in_data.blue_in];
      e.alpha_out = shadow_keep ? in_data.alpha_in : 8'd255;
      expected_pix.push_back(e);
      pixels_sent++;
    end
  end

  // output monitor: oldest expectation first, field by field
  always @(posedge clk) begin
    ptal_pkg::pix_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_pix.size() == 0) begin
        report_mismatch("unexpected result, red_out", int'(out_data.red_out), -1);
      end else begin
        e = expected_pix.pop_front();
        if (out_data.red_out != e.red_out)
          report_mismatch("red_out", out_data.red_out, e.red_out);
        if (out_data.green_out != e.green_out)
          report_mismatch("green_out", out_data.green_out, e.green_out);
        if (out_data.blue_out != e.blue_out)
          report_mismatch("blue_out", out_data.blue_out, e.blue_out);
        if (out_data.alpha_out != e.alpha_out)
          report_mismatch("alpha_out", out_data.alpha_out, e.alpha_out);
        pixels_checked++;
      end
    end
  end

  // driver: hold a request until taken, then gap or take the next one
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_data  <= pixel_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, or the long hold-off
  always @(negedge clk) begin
    if (rst || long_hold) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
    apply_setting(idx, val);
    cfg_writes++;
  endtask

  // all requests in, all results back, pipeline drained
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || expected_pix.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic void queue_pixels(int count);
    ptal_pkg::pix_in_t p;
    for (int i = 0; i < count; i++) begin
      p = ptal_pkg::pix_in_t'($urandom);
      if ($urandom_range(0, 9) == 0) p.red_in = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if ($urandom_range(0, 9) == 0) p.blue_in = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      pixel_q.push_back(p);
    end
  endfunction

  function automatic void queue_directed();
    pixel_q.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{8'd1, 8'd127, 8'd128, 8'd254});
    pixel_q.push_back('{8'd254, 8'd126, 8'd2, 8'd1});
    pixel_q.push_back('{8'h55, 8'hAA, 8'h0F, 8'hF0});
    pixel_q.push_back('{8'hAA, 8'h55, 8'hF0, 8'h0F});
    for (int k = 0; k < 8; k++)
      pixel_q.push_back('{8'(1 << k), 8'(~(1 << k)), 8'(255 - 32 * k), 8'(32 * k)});
  endfunction

  initial begin
    shadow_mode = ptal_pkg::MODE_BRIGHT;
    shadow_bright = 0;
    shadow_contrast = 100;
    shadow_gamma = 100;
    shadow_keep = 1'b1;
    log2_fix[0] = '0;
    for (int x = 1; x < 256; x++) log2_fix[x] = fixed_log2(x);
    rebuild_tone_curve();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset state is the identity: directed pixels, no idling
    no_gaps = 1;
    queue_directed();
    wait_drained();
    no_gaps = 0;
    queue_pixels(120);
    wait_drained();

    // brightness extremes, alpha forced opaque
    write_reg(ptal_pkg::CFG_BRIGHT, 10'd100);
    queue_directed();
    queue_pixels(100);
    wait_drained();
    write_reg(ptal_pkg::CFG_ALPHA, 10'd0);
    write_reg(ptal_pkg::CFG_BRIGHT, 10'h080);  // -128, out of range
    queue_directed();
    queue_pixels(100);
    wait_drained();
    write_reg(ptal_pkg::CFG_BRIGHT, 10'h07F);
    write_reg(3'd5, 10'h3FF);        // unmapped, ignored
    write_reg(3'd7, 10'h155);
    queue_pixels(100);
    wait_drained();

    // contrast: flat, steepest, random; long output hold-off here
    write_reg(ptal_pkg::CFG_MODE, 10'(ptal_pkg::MODE_CONTRAST));
    write_reg(ptal_pkg::CFG_CONTRAST, 10'd0);
    queue_directed();
    queue_pixels(100);
    wait_drained();
    write_reg(ptal_pkg::CFG_CONTRAST, 10'h3FF);
    write_reg(ptal_pkg::CFG_ALPHA, 10'h3FF);
    queue_pixels(150);
    long_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
    join_none
    wait_drained();
    write_reg(ptal_pkg::CFG_CONTRAST, 10'($urandom_range(0, 1000)));
    no_gaps = 1;
    queue_pixels(120);
    wait_drained();
    no_gaps = 0;

    // gamma: neutral, zero, one, maximum, random
    write_reg(ptal_pkg::CFG_MODE, 10'(ptal_pkg::MODE_GAMMA));
    queue_directed();
    queue_pixels(80);
    wait_drained();
    write_reg(ptal_pkg::CFG_GAMMA, 10'd0);
    queue_pixels(80);
    wait_drained();
    write_reg(ptal_pkg::CFG_GAMMA, 10'd1);
    queue_directed();
    queue_pixels(80);
    wait_drained();
    write_reg(ptal_pkg::CFG_GAMMA, 10'h3FF);
    queue_directed();
    queue_pixels(80);
    wait_drained();
    write_reg(ptal_pkg::CFG_GAMMA, 10'($urandom_range(1, 1000)));
    queue_pixels(120);
    wait_drained();

    // bypass mode code: identity
    write_reg(ptal_pkg::CFG_MODE, 10'h3FF);
    queue_pixels(100);
    wait_drained();

    // back to brightness at a random negative and positive amount
    write_reg(ptal_pkg::CFG_MODE, 10'(ptal_pkg::MODE_BRIGHT));
    write_reg(ptal_pkg::CFG_BRIGHT,
              10'($unsigned(8'($signed($urandom_range(0, 200)) - 100))));
    queue_pixels(150);
    wait_drained();
    write_reg(ptal_pkg::CFG_BRIGHT, 10'($urandom_range(0, 255)));
    queue_pixels(150);
    wait_drained();

    repeat (20) @(negedge clk);
    $display("Covered %0d pixels, %0d checked, across %0d register writes",
             pixels_sent, pixels_checked, cfg_writes);
    $display("Modes: brightness, contrast, gamma and bypass, with extremes and idling");
    if (errors == 0) begin
      $display("pixel_tone_adjust_lut_top_tb passed");
    end else begin
      $display("pixel_tone_adjust_lut_top_tb failed");
    end
    $finish;
  end

  // about 19 table rebuilds, plus pixels, with margin
  initial begin
    #12000000;
    $display("Timeout with %0d results outstanding", expected_pix.size());
    $display("pixel_tone_adjust_lut_top_tb failed");
    $finish;
  end

endmodule

@@ pixel_tone_adjust_lut_top.f @@
hw/rtl/ptal_pkg.sv
hw/rtl/ptal_ram.sv
hw/rtl/ptal_build.sv
hw/rtl/pixel_tone_adjust_lut_top.sv
tb/pixel_tone_adjust_lut_top_tb.sv
